FILE: rtl/core/flash_erase_sector_planner_macros.svh
// ----------------------------------------------------------------------------
// Flash erase sector planner assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FLASH_ERASE_SECTOR_PLANNER_MACROS_SVH
`define FLASH_ERASE_SECTOR_PLANNER_MACROS_SVH

// same-cycle implication
`define FSP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Sector map constants, queue entry type and sector lookup functions.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int NUM_SECTORS    = 12;
  localparam int SECTOR_W       = 4;
  localparam int SIZE_W         = 18;
  localparam int OFFS_W         = 21;
  localparam int ADDR_W         = 32;
  localparam int COUNT_W        = 31;  // positive counts only reach the queue
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_ADDR_W     = 3;
  localparam int IN_DATA_W      = 64;
  localparam int OUT_DATA_W     = 56;
  localparam int REG_MAP_BASE   = 0;
  localparam logic [ADDR_W-1:0] MAP_BASE_RESET = 32'h0800_0000;
  localparam logic [SECTOR_W-1:0] LAST_SECTOR = 4'd11;

  typedef struct packed {
    logic                oor;
    logic [SECTOR_W-1:0] sector;
    logic [COUNT_W-1:0]  count;
  } fsp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fsp_qstat_t;

  function automatic logic [SIZE_W-1:0] sector_size(input logic [SECTOR_W-1:0] k);
    logic [SIZE_W-1:0] s;
    case (k)
      4'd0, 4'd1, 4'd2, 4'd3: s = 18'h0_4000;
      4'd4:                   s = 18'h1_0000;
      4'd5, 4'd6, 4'd7, 4'd8,
      4'd9, 4'd10, 4'd11:     s = 18'h2_0000;
      default:                s = '0;
    endcase
    return s;
  endfunction

  // offset of the first byte of sector k from the base; k = 12 is the map end
  function automatic logic [OFFS_W-1:0] sector_offset(input logic [SECTOR_W-1:0] k);
    logic [OFFS_W-1:0] o;
    case (k)
      4'd0:    o = 21'h00_0000;
      4'd1:    o = 21'h00_4000;
      4'd2:    o = 21'h00_8000;
      4'd3:    o = 21'h00_C000;
      4'd4:    o = 21'h01_0000;
      4'd5:    o = 21'h02_0000;
      4'd6:    o = 21'h04_0000;
      4'd7:    o = 21'h06_0000;
      4'd8:    o = 21'h08_0000;
      4'd9:    o = 21'h0A_0000;
      4'd10:   o = 21'h0C_0000;
      4'd11:   o = 21'h0E_0000;
      4'd12:   o = 21'h10_0000;
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

FILE: rtl/core/flash_erase_sector_planner.sv
// ----------------------------------------------------------------------------
// flash_erase_sector_planner
// Turns an erase request into the ordered list of flash sectors to erase.
// ----------------------------------------------------------------------------
// Input stream: one word per request, start address and byte count. A count
// of zero or with its top bit set is taken and produces no result.
// Output stream: one word per sector (index, start address, size); tuser
// flags an address past the last sector, which ends the run with zero data.
// tlast marks the final word of each request.
// The sector map is twelve sectors from the base register (4 x 16 KiB,
// 64 KiB, 7 x 128 KiB); the user writes the base over the cfg port only
// while idle; the block itself does not enforce this. Results are registered.
// Throughput: the back sequencer emits one word per clock while not stalled;
// a request yields 1 to 13 result words. The front takes one request
// per clock into a small queue and stalls only while the queue is full.
// Output stalls hold the result register and the sequencer in place.
// Reset clears the queue, the sequencer and the output valid and loads
// the base register with 0x0800_0000; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "flash_erase_sector_planner_macros.svh"

module flash_erase_sector_planner #(
  parameter int QUEUE_DEPTH = fsp_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fsp_pkg::IN_DATA_W-1:0]     in_tdata,   // start_address, byte_count
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fsp_pkg::OUT_DATA_W-1:0]    out_tdata,  // sector_index, sector_start, sector_bytes
  output logic                              out_tuser,  // out_of_range
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [fsp_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  logic [fsp_pkg::ADDR_W-1:0]          map_base_r, map_base_nxt;
  logic [fsp_pkg::CFG_ADDR_W-3:0]      reg_idx;
  logic                                push;
  logic                                pop;
  fsp_pkg::fsp_entry_t                 push_entry;
  fsp_pkg::fsp_entry_t                 head;
  fsp_pkg::fsp_qstat_t                 qstat;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[fsp_pkg::CFG_ADDR_W-1:2];

  always_comb begin
    map_base_nxt = map_base_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        reg_idx == (fsp_pkg::CFG_ADDR_W-2)'(fsp_pkg::REG_MAP_BASE)) begin
      map_base_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_base_r <= fsp_pkg::MAP_BASE_RESET;
    end else begin
      map_base_r <= map_base_nxt;
    end
  end

  assign cfg_prdata = (reg_idx == (fsp_pkg::CFG_ADDR_W-2)'(fsp_pkg::REG_MAP_BASE)) ?
                      map_base_r : '0;

  fsp_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .map_base   (map_base_r),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  fsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  fsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .map_base   (map_base_r),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `FSP_ASSERT_IMPLY(a_oor_ends_run, out_tvalid && out_tuser, out_tlast, "out of range word without tlast")
  `FSP_ASSERT_IMPLY(a_oor_zero_data, out_tvalid && out_tuser, out_tdata == '0, "out of range word carries data")
  `FSP_ASSERT_IMPLY(a_sector_in_map, out_tvalid && !out_tuser, out_tdata[3:0] <= fsp_pkg::LAST_SECTOR, "sector index past map")
  `FSP_ASSERT_NEXT(a_run_no_bubble, out_tvalid && out_tready && !out_tlast, out_tvalid, "gap inside a run")

endmodule

FILE: rtl/core/fsp_front.sv
// ----------------------------------------------------------------------------
// fsp_front
// Accepts erase requests, drops empty ones and finds the first sector.
// ----------------------------------------------------------------------------
module fsp_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fsp_pkg::IN_DATA_W-1:0]       in_tdata,   // start_address, byte_count
  input  logic [fsp_pkg::ADDR_W-1:0]          map_base,
  input  fsp_pkg::fsp_qstat_t                 qstat,
  output logic                                push,
  output fsp_pkg::fsp_entry_t                 push_entry
);

  logic [fsp_pkg::ADDR_W-1:0]   addr;
  logic [fsp_pkg::ADDR_W-1:0]   cnt;
  logic [fsp_pkg::ADDR_W:0]     diff;
  logic [fsp_pkg::ADDR_W-1:0]   offs;
  logic                         below;
  logic                         past_end;
  logic [fsp_pkg::SECTOR_W-1:0] first_k;

  assign addr  = in_tdata[fsp_pkg::ADDR_W-1:0];
  assign cnt   = in_tdata[2*fsp_pkg::ADDR_W-1:fsp_pkg::ADDR_W];
  assign diff  = {1'b0, addr} - {1'b0, map_base};
  assign below = diff[fsp_pkg::ADDR_W];
  assign offs  = diff[fsp_pkg::ADDR_W-1:0];

  // constant compares against each sector end; lowest matching sector wins
  always_comb begin
    first_k = '0;
    for (int k = fsp_pkg::NUM_SECTORS - 1; k >= 0; k--) begin
      if (offs < fsp_pkg::ADDR_W'(fsp_pkg::sector_offset(fsp_pkg::SECTOR_W'(k + 1)))) begin
        first_k = fsp_pkg::SECTOR_W'(k);
      end
    end
    if (below) begin
      first_k = '0;
    end
  end

  assign past_end = !below &&
    (offs >= fsp_pkg::ADDR_W'(fsp_pkg::sector_offset(fsp_pkg::SECTOR_W'(fsp_pkg::NUM_SECTORS))));

  assign in_tready = !qstat.full;
  // zero or negative counts are taken and produce nothing
  assign push = in_tvalid && in_tready && !cnt[fsp_pkg::ADDR_W-1] && (cnt != '0);

  assign push_entry.oor    = past_end;
  assign push_entry.sector = first_k;
  assign push_entry.count  = cnt[fsp_pkg::COUNT_W-1:0];

endmodule

FILE: rtl/core/fsp_queue.sv
// ----------------------------------------------------------------------------
// fsp_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module fsp_queue #(
  parameter int DEPTH = fsp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fsp_pkg::fsp_entry_t push_entry,
  input  logic                pop,
  output fsp_pkg::fsp_entry_t head,
  output fsp_pkg::fsp_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  fsp_pkg::fsp_entry_t slot_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head        = slot_r[rd_ptr_r];
  assign qstat.full  = (fill_r == CNT_FULL);
  assign qstat.empty = (fill_r == '0);

endmodule

FILE: rtl/core/fsp_back.sv
// ----------------------------------------------------------------------------
// fsp_back
// Walks the sectors of one request, one result word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module fsp_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [fsp_pkg::ADDR_W-1:0]       map_base,
  input  fsp_pkg::fsp_qstat_t              qstat,
  input  fsp_pkg::fsp_entry_t              head,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fsp_pkg::OUT_DATA_W-1:0]   out_tdata,  // sector_index, sector_start, sector_bytes
  output logic                             out_tuser,  // out_of_range
  output logic                             out_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OOR  = 3'b100
  } bstate_t;

  bstate_t                      state_r, state_nxt;
  logic [fsp_pkg::SECTOR_W-1:0] k_r, k_nxt;
  logic [fsp_pkg::ADDR_W-1:0]   rem_r, rem_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [fsp_pkg::SECTOR_W-1:0] idx_r;
  logic [fsp_pkg::ADDR_W-1:0]   start_r;
  logic [fsp_pkg::SIZE_W-1:0]   bytes_r;
  logic                         oor_r;
  logic                         last_r;

  logic                         have_work;
  logic                         step;
  logic                         cur_oor;
  logic [fsp_pkg::SECTOR_W-1:0] cur_k;
  logic [fsp_pkg::ADDR_W-1:0]   cur_rem;
  logic [fsp_pkg::ADDR_W-1:0]   rem_after;
  logic                         done;
  logic [fsp_pkg::SIZE_W-1:0]   cur_size;

  always_comb begin
    have_work = 1'b0;
    cur_oor   = 1'b0;
    cur_k     = k_r;
    cur_rem   = rem_r;
    unique case (state_r)
      ST_IDLE: begin
        have_work = !qstat.empty;
        cur_oor   = head.oor;
        cur_k     = head.sector;
        cur_rem   = {1'b0, head.count};
      end
      ST_RUN: begin
        have_work = 1'b1;
      end
      ST_OOR: begin
        have_work = 1'b1;
        cur_oor   = 1'b1;
      end
      default: ;
    endcase
  end

  assign step      = have_work && (!out_valid_r || out_tready);
  assign pop       = step && (state_r == ST_IDLE);
  assign cur_size  = fsp_pkg::sector_size(cur_k);
  assign rem_after = cur_rem - fsp_pkg::ADDR_W'(cur_size);
  // count is positive below 2^31, so bit 31 is the sign of what is left
  assign done      = cur_oor || rem_after[fsp_pkg::ADDR_W-1] || (rem_after == '0);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      k_nxt         = cur_k + 1'b1;
      rem_nxt       = rem_after;
      if (done) begin
        state_nxt = ST_IDLE;
      end else if (cur_k == fsp_pkg::LAST_SECTOR) begin
        state_nxt = ST_OOR;
      end else begin
        state_nxt = ST_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
    if (step) begin
      idx_r   <= cur_oor ? '0 : cur_k;
      start_r <= cur_oor ? '0 : map_base + fsp_pkg::ADDR_W'(fsp_pkg::sector_offset(cur_k));
      bytes_r <= cur_oor ? '0 : cur_size;
      oor_r   <= cur_oor;
      last_r  <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, bytes_r, start_r, idx_r};
  assign out_tuser  = oor_r;
  assign out_tlast  = last_r;

endmodule
